@@ rtl/prc_pkg.sv @@
`timescale 1ns / 1ps
// Package for the packed raster crop unit: register indexes, format codes,
// queue sizes and the records passed between front, queue and back.
// No dependencies.
package prc_pkg;

   localparam int COORD_MAX_BITS = 24;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 4;
   localparam int PIX_BITS       = 7;
   localparam int BYTE_BITS      = 8;

   localparam logic [CSR_INDEX_BITS-1:0] REG_SOURCE_WIDTH  = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SOURCE_HEIGHT = 4'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CROP_LEFT     = 4'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CROP_TOP      = 4'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CROP_WIDTH    = 4'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CROP_HEIGHT   = 4'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FORMAT_CODE   = 4'd6;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SWAP_SIXTEEN  = 4'd7;

   localparam logic [2:0] DEPTH_CODE_1  = 3'd0;
   localparam logic [2:0] DEPTH_CODE_4  = 3'd2;
   localparam logic [2:0] DEPTH_CODE_8  = 3'd3;
   localparam logic [2:0] DEPTH_CODE_16 = 3'd4;

   localparam logic [5:0]          FORMAT_RESET    = 6'd11;
   localparam logic [PIX_BITS-1:0] SWAP_PIXEL_BITS = 7'd16;

   localparam int         SETTLE_BITS   = 2;
   localparam logic [1:0] SETTLE_CYCLES = 2'd2;

   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = 2;
   localparam int OUT_DEPTH      = 4;
   localparam int OUT_PTR_BITS   = 2;
   localparam logic [OUT_PTR_BITS:0] OUT_TAKE_LIMIT = 3'd2;

   typedef struct packed {
      logic settled;
      logic cfg_ok;
      logic swap_active;
   } cfg_flags_type;

   typedef struct packed {
      logic       is_error;
      logic       row_end;
      logic       last_row;
      logic [3:0] count;
      logic [7:0] bits;
   } entry_type;

   typedef struct packed {
      logic [7:0] data;
      logic       row_last;
      logic       frame_last;
      logic       status;
   } result_type;

endpackage

@@ rtl/prc_csr.sv @@
`timescale 1ns / 1ps
// Configuration registers and derived crop geometry (two registered stages).
// Depends on prc_pkg.
module prc_csr #(
   parameter int COORD_BITS = 16,
   parameter int BW         = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [prc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [prc_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output logic [COORD_BITS-1:0]               source_height,
   output logic [COORD_BITS-1:0]               crop_top,
   output logic [COORD_BITS:0]                 top_end,
   output logic [BW-1:0]                       row_bits,
   output logic [BW-1:0]                       lo_bits,
   output logic [BW-1:0]                       hi_bits,
   output prc_pkg::cfg_flags_type              flags
);

   logic [prc_pkg::COORD_MAX_BITS-1:0] wide_data;
   logic [COORD_BITS-1:0]              coord_value;

   logic [COORD_BITS-1:0] width_ff, height_ff, left_ff, top_ff, cw_ff, ch_ff;
   logic [5:0]            format_ff;
   logic                  swap_ff;
   logic [prc_pkg::SETTLE_BITS-1:0] settle_ff;

   logic [prc_pkg::PIX_BITS-1:0] pb_in, pb_ff;
   logic [COORD_BITS:0]          lpw_in, lpw_ff, tph_in, tph_ff;
   logic [BW-1:0]                row_bits_in, row_bits_ff, lo_in, lo_ff, hi_in, hi_ff;
   logic                         ok_in, ok_ff, swap_act_in, swap_act_ff;
   logic [2:0]                   channels;

   assign wide_data = {{(prc_pkg::COORD_MAX_BITS - prc_pkg::CSR_DATA_BITS){1'b0}}, csr_wdata};
   assign coord_value = wide_data[COORD_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= COORD_BITS'(1);
         height_ff <= COORD_BITS'(1);
         left_ff   <= '0;
         top_ff    <= '0;
         cw_ff     <= COORD_BITS'(1);
         ch_ff     <= COORD_BITS'(1);
         format_ff <= prc_pkg::FORMAT_RESET;
         swap_ff   <= 1'b0;
         settle_ff <= prc_pkg::SETTLE_CYCLES;
      end else if (csr_we) begin
         settle_ff <= prc_pkg::SETTLE_CYCLES;
         unique case (csr_index)
            prc_pkg::REG_SOURCE_WIDTH:  width_ff  <= coord_value;
            prc_pkg::REG_SOURCE_HEIGHT: height_ff <= coord_value;
            prc_pkg::REG_CROP_LEFT:     left_ff   <= coord_value;
            prc_pkg::REG_CROP_TOP:      top_ff    <= coord_value;
            prc_pkg::REG_CROP_WIDTH:    cw_ff     <= coord_value;
            prc_pkg::REG_CROP_HEIGHT:   ch_ff     <= coord_value;
            prc_pkg::REG_FORMAT_CODE:   format_ff <= csr_wdata[5:0];
            prc_pkg::REG_SWAP_SIXTEEN:  swap_ff   <= csr_wdata[0];
            default: ;
         endcase
      end else if (settle_ff != '0) begin
         settle_ff <= settle_ff - prc_pkg::SETTLE_BITS'(1);
      end
   end

   assign channels = format_ff[5:3];

   always_comb begin
      unique case (format_ff[2:0])
         prc_pkg::DEPTH_CODE_1:  pb_in = {4'b0000, channels};
         prc_pkg::DEPTH_CODE_4:  pb_in = {2'b00, channels, 2'b00};
         prc_pkg::DEPTH_CODE_8:  pb_in = {1'b0, channels, 3'b000};
         prc_pkg::DEPTH_CODE_16: pb_in = {channels, 4'b0000};
         default:                pb_in = '0;
      endcase
   end

   assign lpw_in = {1'b0, left_ff} + {1'b0, cw_ff};
   assign tph_in = {1'b0, top_ff} + {1'b0, ch_ff};

   assign row_bits_in = {{(BW - COORD_BITS){1'b0}}, width_ff}
                      * {{(BW - prc_pkg::PIX_BITS){1'b0}}, pb_ff};
   assign lo_in       = {{(BW - COORD_BITS){1'b0}}, left_ff}
                      * {{(BW - prc_pkg::PIX_BITS){1'b0}}, pb_ff};
   assign hi_in       = {{(BW - COORD_BITS - 1){1'b0}}, lpw_ff}
                      * {{(BW - prc_pkg::PIX_BITS){1'b0}}, pb_ff};
   assign ok_in = (pb_ff != '0) && (width_ff != '0) && (height_ff != '0)
               && (cw_ff != '0) && (ch_ff != '0)
               && (lpw_ff <= {1'b0, width_ff}) && (tph_ff <= {1'b0, height_ff});
   assign swap_act_in = swap_ff && (pb_ff == prc_pkg::SWAP_PIXEL_BITS);

   always_ff @(posedge clock) begin
      pb_ff       <= pb_in;
      lpw_ff      <= lpw_in;
      tph_ff      <= tph_in;
      row_bits_ff <= row_bits_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      ok_ff       <= ok_in;
      swap_act_ff <= swap_act_in;
   end

   assign source_height     = height_ff;
   assign crop_top          = top_ff;
   assign top_end           = tph_ff;
   assign row_bits          = row_bits_ff;
   assign lo_bits           = lo_ff;
   assign hi_bits           = hi_ff;
   assign flags.settled     = (settle_ff == '0);
   assign flags.cfg_ok      = ok_ff;
   assign flags.swap_active = swap_act_ff;

endmodule

@@ rtl/prc_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts source words, tracks row and bit position, selects the
// cropped bits of each word and queues them. Depends on prc_pkg.
module prc_front #(
   parameter int COORD_BITS = 16,
   parameter int BW         = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   restart,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,
   input  logic [COORD_BITS-1:0]  source_height,
   input  logic [COORD_BITS-1:0]  crop_top,
   input  logic [COORD_BITS:0]    top_end,
   input  logic [BW-1:0]          row_bits,
   input  logic [BW-1:0]          lo_bits,
   input  logic [BW-1:0]          hi_bits,
   input  prc_pkg::cfg_flags_type flags,
   input  logic                   queue_full,
   output logic                   push,
   output prc_pkg::entry_type     push_entry
);

   logic [BW-1:0]         pos_ff, pos_next8, first_bit, stop_bit, start_off, span;
   logic [COORD_BITS-1:0] row_ff;
   logic                  err_ff;
   logic [COORD_BITS:0]   row_ext, row_inc;
   logic                  in_rows, last_row, hit, row_end, err_now, need_push, take;
   logic [2:0]            offset;
   logic [3:0]            count;
   logic [7:0]            bits;

   assign pos_next8 = pos_ff + BW'(prc_pkg::BYTE_BITS);
   assign row_ext   = {1'b0, row_ff};
   assign row_inc   = row_ext + (COORD_BITS + 1)'(1);

   assign in_rows  = (row_ff >= crop_top) && (row_ext < top_end);
   assign last_row = (row_inc == top_end);

   assign first_bit = (pos_ff >= lo_bits) ? pos_ff : lo_bits;
   assign stop_bit  = (pos_next8 <= hi_bits) ? pos_next8 : hi_bits;
   assign start_off = first_bit - pos_ff;
   assign span      = stop_bit - first_bit;

   assign hit     = in_rows && (stop_bit > first_bit);
   assign row_end = hit && (hi_bits <= pos_next8);
   assign offset  = start_off[2:0];
   assign count   = span[3:0];
   assign bits    = (req_tdata << offset) & ~(8'hFF >> count);

   assign err_now   = (pos_ff == '0) && (row_ff == '0) && !flags.cfg_ok;
   assign need_push = err_now || hit;

   assign req_tready = flags.settled && (err_ff || !need_push || !queue_full);
   assign take       = req_tvalid && req_tready;
   assign push       = take && !err_ff && need_push;

   assign push_entry.is_error = err_now;
   assign push_entry.row_end  = row_end;
   assign push_entry.last_row = last_row;
   assign push_entry.count    = count;
   assign push_entry.bits     = bits;

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         pos_ff <= '0;
         row_ff <= '0;
         err_ff <= 1'b0;
      end else if (take && !err_ff) begin
         if (err_now) begin
            err_ff <= 1'b1;
         end else if (pos_next8 >= row_bits) begin
            pos_ff <= '0;
            row_ff <= (row_inc >= {1'b0, source_height}) ? '0 : row_inc[COORD_BITS-1:0];
         end else begin
            pos_ff <= pos_next8;
         end
      end
   end

endmodule

@@ rtl/prc_fifo.sv @@
`timescale 1ns / 1ps
// Short queue of selected-bit records between front and back.
// Depends on prc_pkg.
module prc_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               flush,
   input  logic               push,
   input  prc_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output prc_pkg::entry_type head
);

   prc_pkg::entry_type mem_ff [prc_pkg::QUEUE_DEPTH];
   logic [prc_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [prc_pkg::QUEUE_PTR_BITS:0]   count_ff;
   logic                               do_push, do_pop;

   assign full    = (count_ff == (prc_pkg::QUEUE_PTR_BITS + 1)'(prc_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || flush) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + prc_pkg::QUEUE_PTR_BITS'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + prc_pkg::QUEUE_PTR_BITS'(1);
         end
         unique case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + (prc_pkg::QUEUE_PTR_BITS + 1)'(1);
            2'b01:   count_ff <= count_ff - (prc_pkg::QUEUE_PTR_BITS + 1)'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

@@ rtl/prc_back.sv @@
`timescale 1ns / 1ps
// Back end: packs selected bits into output words, applies the 16-bit pair
// swap and buffers results for the response channel. Depends on prc_pkg.
module prc_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   restart,
   input  logic                   head_valid,
   input  prc_pkg::entry_type     head,
   output logic                   pop,
   input  prc_pkg::cfg_flags_type flags,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,  // out_byte
   output logic                   rsp_tlast,  // row_last
   output logic [1:0]             rsp_tuser   // [0] frame_last, [1] status
);

   logic [7:0] buf_ff, buf_in, held_ff, held_in;
   logic [2:0] pc_ff, pc_in;
   logic       held_valid_ff, held_valid_in;

   prc_pkg::result_type out_mem_ff [prc_pkg::OUT_DEPTH];
   logic [prc_pkg::OUT_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [prc_pkg::OUT_PTR_BITS:0]   count_ff;

   logic [15:0] merged;
   logic [3:0]  total;
   logic        emit0, emit1, rsp_pop;
   prc_pkg::result_type dlv [2];
   logic                dlv_valid [2];
   prc_pkg::result_type slot [2];
   logic [1:0]          nout;

   assign pop     = head_valid && (count_ff <= prc_pkg::OUT_TAKE_LIMIT);
   assign rsp_pop = rsp_tvalid && rsp_tready;

   assign merged = {buf_ff, 8'h00} | ({head.bits, 8'h00} >> pc_ff);
   assign total  = {1'b0, pc_ff} + head.count;
   assign emit0  = total[3] || head.row_end;
   assign emit1  = head.row_end && total[3] && (total[2:0] != 3'd0);

   always_comb begin
      dlv[0].data       = merged[15:8];
      dlv[0].row_last   = head.row_end && !emit1;
      dlv[0].frame_last = head.row_end && !emit1 && head.last_row;
      dlv[0].status     = 1'b0;
      dlv[1].data       = merged[7:0];
      dlv[1].row_last   = 1'b1;
      dlv[1].frame_last = head.last_row;
      dlv[1].status     = 1'b0;
      dlv_valid[0]      = emit0;
      dlv_valid[1]      = emit1;
   end

   always_comb begin
      slot[0]       = '0;
      slot[1]       = '0;
      nout          = 2'd0;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      if (head.is_error) begin
         slot[0].status = 1'b1;
         nout           = 2'd1;
      end else if (!flags.swap_active) begin
         slot[0] = dlv[0];
         slot[1] = dlv[1];
         nout    = {emit1, emit0 && !emit1};
      end else begin
         for (int i = 0; i < 2; i++) begin
            if (dlv_valid[i]) begin
               if (!held_valid_in) begin
                  held_in       = dlv[i].data;
                  held_valid_in = 1'b1;
               end else begin
                  slot[0].data     = dlv[i].data;
                  slot[1].data     = held_in;
                  slot[1].row_last   = dlv[i].row_last;
                  slot[1].frame_last = dlv[i].frame_last;
                  nout             = 2'd2;
                  held_valid_in    = 1'b0;
               end
            end
         end
      end
   end

   assign pc_in  = head.row_end ? 3'd0 : total[2:0];
   assign buf_in = head.row_end ? 8'h00 : (total[3] ? merged[7:0] : merged[15:8]);

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         buf_ff        <= '0;
         pc_ff         <= '0;
         held_valid_ff <= 1'b0;
      end else if (pop && !head.is_error) begin
         buf_ff        <= buf_in;
         pc_ff         <= pc_in;
         held_valid_ff <= held_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && !head.is_error) begin
         held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && (nout != 2'd0)) begin
         out_mem_ff[wr_ptr_ff] <= slot[0];
      end
      if (pop && (nout == 2'd2)) begin
         out_mem_ff[wr_ptr_ff + prc_pkg::OUT_PTR_BITS'(1)] <= slot[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (pop) begin
            wr_ptr_ff <= wr_ptr_ff + prc_pkg::OUT_PTR_BITS'(nout);
         end
         if (rsp_pop) begin
            rd_ptr_ff <= rd_ptr_ff + prc_pkg::OUT_PTR_BITS'(1);
         end
         count_ff <= count_ff
                   + (pop ? (prc_pkg::OUT_PTR_BITS + 1)'(nout) : '0)
                   - (prc_pkg::OUT_PTR_BITS + 1)'(rsp_pop);
      end
   end

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = out_mem_ff[rd_ptr_ff].data;
   assign rsp_tlast  = out_mem_ff[rd_ptr_ff].row_last;
   assign rsp_tuser  = {out_mem_ff[rd_ptr_ff].status, out_mem_ff[rd_ptr_ff].frame_last};

endmodule

@@ rtl/packed_raster_crop_unit.sv @@
`timescale 1ns / 1ps
// Top level of the packed raster crop unit: register file, front end,
// record queue and back end. Depends on prc_pkg and the prc_* modules.
//
// Takes up to one source body word per cycle on req_ and delivers up to one
// result word per cycle on rsp_; a source word can cause up to two result
// words, which a four-entry output buffer absorbs while the back end keeps pace
// with the front end through a four-entry record queue. After reset and after
// every register write req_tready stays low while the crop geometry products
// are formed in two register stages. The user must write registers only while
// the unit is idle (the unit does not enforce it); any write restarts the frame.
// A bad format or a rectangle outside the source yields one result with status
// set, and the rest of the frame is dropped until the next register write or reset.
module packed_raster_crop_unit #(
   parameter int COORD_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,  // in_byte
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [7:0]                         rsp_tdata,  // out_byte
   output logic                               rsp_tlast,  // row_last
   output logic [1:0]                         rsp_tuser,  // [0] frame_last, [1] status
   input  logic                               csr_we,
   input  logic [prc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [prc_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int BW = COORD_BITS + 8;

   logic [COORD_BITS-1:0]  source_height, crop_top;
   logic [COORD_BITS:0]    top_end;
   logic [BW-1:0]          row_bits, lo_bits, hi_bits;
   prc_pkg::cfg_flags_type flags;
   logic                   queue_full, queue_empty, push, pop;
   prc_pkg::entry_type     push_entry, head;

   prc_csr #(.COORD_BITS(COORD_BITS), .BW(BW)) u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .source_height (source_height),
      .crop_top      (crop_top),
      .top_end       (top_end),
      .row_bits      (row_bits),
      .lo_bits       (lo_bits),
      .hi_bits       (hi_bits),
      .flags         (flags)
   );

   prc_front #(.COORD_BITS(COORD_BITS), .BW(BW)) u_front (
      .clock         (clock),
      .reset         (reset),
      .restart       (csr_we),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .source_height (source_height),
      .crop_top      (crop_top),
      .top_end       (top_end),
      .row_bits      (row_bits),
      .lo_bits       (lo_bits),
      .hi_bits       (hi_bits),
      .flags         (flags),
      .queue_full    (queue_full),
      .push          (push),
      .push_entry    (push_entry)
   );

   prc_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .flush      (csr_we),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .empty      (queue_empty),
      .head       (head)
   );

   prc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .restart    (csr_we),
      .head_valid (!queue_empty),
      .head       (head),
      .pop        (pop),
      .flags      (flags),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ rtl/prc_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the packed raster crop unit, bound to its top level.
// Depends on packed_raster_crop_unit.
module prc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic [1:0] rsp_tuser,
   input logic       csr_we
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled response word changed");

   a_error_word: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata == 8'h00 && !rsp_tlast && !rsp_tuser[0])
      else $error("error word carries data or end marks");

   a_frame_end_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast)
      else $error("frame end without row end");

   a_settle: assert property (@(posedge clock)
      reset || csr_we |=> !req_tready)
      else $error("source accepted before geometry settled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response offered right after reset");

endmodule

bind packed_raster_crop_unit prc_checker u_prc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser),
   .csr_we     (csr_we)
);

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for packed_raster_crop_unit. It crops a stream of image
// body words under many register settings and checks each result word against
// a cycle-free model of the crop. Depends on prc_pkg and the unit's RTL.
module tb;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int IDLE_SETTLE  = 30;
   localparam int TARGET_WORDS = 1050;
   localparam int REPORT_CAP   = 200;

   typedef logic [7:0] word_q_type[$];

   typedef struct packed {
      logic [15:0] src_w;
      logic [15:0] src_h;
      logic [15:0] left;
      logic [15:0] top;
      logic [15:0] width;
      logic [15:0] height;
      logic [5:0]  fmt;
      logic        swap;
   } crop_setting_type;

   typedef enum int {BAD_FORMAT, ZERO_SIZE, OVER_RIGHT, OVER_BOTTOM} fault_type;
   typedef enum int {DRAIN_FREE, DRAIN_COIN, DRAIN_TRICKLE, DRAIN_PERIODIC} drain_mode_type;

   class crop_scoreboard;
      int         src_w, src_h, left, top, width, height;
      logic [5:0] fmt;
      logic       swap_en;
      int         bit_pos, row, pack_n;
      logic [7:0] pack, held;
      bit         held_ok, dropped;
      prc_pkg::result_type cropped_words[$];
      int         errors, checked;

      function new();
         src_w = 1; src_h = 1; left = 0; top = 0; width = 1; height = 1;
         fmt = prc_pkg::FORMAT_RESET;
         swap_en = 1'b0;
         errors = 0;
         checked = 0;
         restart();
      endfunction

      function void restart();
         bit_pos = 0; row = 0; pack = '0; pack_n = 0;
         held = '0; held_ok = 1'b0; dropped = 1'b0;
      endfunction

      static function int pixel_size(logic [5:0] f);
         int depth;
         case (f[2:0])
            prc_pkg::DEPTH_CODE_1:  depth = 1;
            prc_pkg::DEPTH_CODE_4:  depth = 4;
            prc_pkg::DEPTH_CODE_8:  depth = 8;
            prc_pkg::DEPTH_CODE_16: depth = 16;
            default:                depth = 0;
         endcase
         return int'(f[5:3]) * depth;
      endfunction

      function void write_reg(logic [prc_pkg::CSR_INDEX_BITS-1:0] idx,
                              logic [prc_pkg::CSR_DATA_BITS-1:0] val);
         case (idx)
            prc_pkg::REG_SOURCE_WIDTH:  src_w = int'(val);
            prc_pkg::REG_SOURCE_HEIGHT: src_h = int'(val);
            prc_pkg::REG_CROP_LEFT:     left = int'(val);
            prc_pkg::REG_CROP_TOP:      top = int'(val);
            prc_pkg::REG_CROP_WIDTH:    width = int'(val);
            prc_pkg::REG_CROP_HEIGHT:   height = int'(val);
            prc_pkg::REG_FORMAT_CODE:   fmt = val[5:0];
            prc_pkg::REG_SWAP_SIXTEEN:  swap_en = val[0];
            default: ;
         endcase
         restart();
      endfunction

      function bit geometry_ok();
         if (pixel_size(fmt) == 0) return 1'b0;
         if (src_w == 0 || src_h == 0 || width == 0 || height == 0) return 1'b0;
         if (left + width > src_w) return 1'b0;
         if (top + height > src_h) return 1'b0;
         return 1'b1;
      endfunction

      function void push(logic [7:0] d, logic rl, logic fl, logic st);
         prc_pkg::result_type r;
         r.data = d;
         r.row_last = rl;
         r.frame_last = fl;
         r.status = st;
         cropped_words.push_back(r);
      endfunction

      function void emit(logic [7:0] v, logic rl, logic fl, bit swapping);
         if (!swapping) begin
            push(v, rl, fl, 1'b0);
         end else if (!held_ok) begin
            held = v;
            held_ok = 1'b1;
         end else begin
            push(v, 1'b0, 1'b0, 1'b0);
            push(held, rl, fl, 1'b0);
            held_ok = 1'b0;
         end
      endfunction

      function void note_source_word(logic [7:0] w);
         int         pb, row_bits, lo, hi, b;
         bit         in_rows, last_row, swapping, at_end;
         logic [7:0] v;
         if (dropped) return;
         if (bit_pos == 0 && row == 0 && !geometry_ok()) begin
            dropped = 1'b1;
            push('0, 1'b0, 1'b0, 1'b1);
            return;
         end
         pb = pixel_size(fmt);
         row_bits = src_w * pb;
         lo = left * pb;
         hi = (left + width) * pb;
         in_rows = row >= top && row < top + height;
         last_row = (row + 1 == top + height);
         swapping = swap_en && pb == int'(prc_pkg::SWAP_PIXEL_BITS);
         for (int i = 0; i < 8; i++) begin
            b = bit_pos + i;
            if (b >= row_bits) break;
            if (in_rows && b >= lo && b < hi) begin
               at_end = (b + 1 == hi);
               pack = {pack[6:0], w[7-i]};
               pack_n++;
               if (pack_n == 8 || at_end) begin
                  v = pack << (8 - pack_n);
                  emit(v, at_end, at_end && last_row, swapping);
                  pack = '0;
                  pack_n = 0;
               end
            end
         end
         bit_pos += 8;
         if (bit_pos >= row_bits) begin
            bit_pos = 0;
            row++;
            if (row >= src_h) row = 0;
         end
      endfunction

      function void check_cropped_word(logic [7:0] d, logic rl, logic fl, logic st);
         prc_pkg::result_type e;
         checked++;
         if (cropped_words.size() == 0) begin
            errors++;
            if (errors <= REPORT_CAP)
               $display("%0t: unexpected rsp word %02h row_last %0b frame_last %0b status %0b",
                        $time, d, rl, fl, st);
            return;
         end
         e = cropped_words.pop_front();
         if (e.data !== d || e.row_last !== rl || e.frame_last !== fl || e.status !== st) begin
            errors++;
            if (errors <= REPORT_CAP)
               $display("%0t: rsp mismatch, expected %02h/%0b/%0b/%0b got %02h/%0b/%0b/%0b %s",
                        $time, e.data, e.row_last, e.frame_last, e.status, d, rl, fl, st,
                        "(data/row_last/frame_last/status)");
         end
      endfunction

      function int pending();
         return cropped_words.size();
      endfunction
   endclass

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [7:0]                         req_tdata = '0;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [7:0]                         rsp_tdata;   // out_byte
   logic                               rsp_tlast;   // row_last
   logic [1:0]                         rsp_tuser;   // [0] frame_last, [1] status
   logic                               csr_we = 1'b0;
   logic [prc_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [prc_pkg::CSR_DATA_BITS-1:0]  csr_wdata = '0;

   int             cycles = 0;
   drain_mode_type drain_mode = DRAIN_FREE;
   crop_scoreboard sb = new();

   packed_raster_crop_unit #(.COORD_BITS(16)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) sb.write_reg(csr_index, csr_wdata);
         if (req_tvalid && req_tready) sb.note_source_word(req_tdata);
         if (rsp_tvalid && rsp_tready)
            sb.check_cropped_word(rsp_tdata, rsp_tlast, rsp_tuser[0], rsp_tuser[1]);
      end
   end

   always @(posedge clock) begin
      if (cycles % 256 == 0) drain_mode <= drain_mode_type'($urandom_range(0, 3));
      case (drain_mode)
         DRAIN_FREE:    rsp_tready <= 1'b1;
         DRAIN_COIN:    rsp_tready <= 1'($urandom_range(0, 1));
         DRAIN_TRICKLE: rsp_tready <= ($urandom_range(0, 7) == 0);
         default:       rsp_tready <= (cycles[4:3] != 2'b11);
      endcase
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic crop_setting_type make_setting(int sw, int sh, int cl, int ct, int cw,
                                                     int chh, logic [5:0] f, logic swp);
      crop_setting_type s;
      s.src_w = 16'(sw); s.src_h = 16'(sh); s.left = 16'(cl); s.top = 16'(ct);
      s.width = 16'(cw); s.height = 16'(chh); s.fmt = f; s.swap = swp;
      return s;
   endfunction

   function automatic crop_setting_type pick_valid(bit big);
      int         chn, pb, max_w, sw, sh, cl, ct;
      logic [2:0] dc;
      chn = $urandom_range(1, 7);
      case ($urandom_range(0, 3))
         0:       dc = prc_pkg::DEPTH_CODE_1;
         1:       dc = prc_pkg::DEPTH_CODE_4;
         2:       dc = prc_pkg::DEPTH_CODE_8;
         default: dc = prc_pkg::DEPTH_CODE_16;
      endcase
      if ($urandom_range(0, 3) == 0) begin
         case ($urandom_range(0, 2))
            0:       begin chn = 1; dc = prc_pkg::DEPTH_CODE_16; end
            1:       begin chn = 2; dc = prc_pkg::DEPTH_CODE_8; end
            default: begin chn = 4; dc = prc_pkg::DEPTH_CODE_4; end
         endcase
      end
      pb = crop_scoreboard::pixel_size({chn[2:0], dc});
      if (big) begin
         sw = $urandom_range(1000, 65535);
         sh = $urandom_range(1000, 65535);
         cl = $urandom_range(0, 64);
         ct = $urandom_range(0, 1);
      end else begin
         max_w = 192 / pb;
         if (max_w < 1) max_w = 1;
         if (max_w > 20) max_w = 20;
         sw = $urandom_range(1, max_w);
         sh = $urandom_range(1, 5);
         cl = $urandom_range(0, sw - 1);
         ct = $urandom_range(0, sh - 1);
      end
      return make_setting(sw, sh, cl, ct, $urandom_range(1, sw - cl), $urandom_range(1, sh - ct),
                          {chn[2:0], dc}, 1'($urandom_range(0, 1)));
   endfunction

   function automatic crop_setting_type pick_fault(fault_type kind);
      crop_setting_type s;
      int               floor_v;
      s = pick_valid(1'b0);
      case (kind)
         BAD_FORMAT: begin
            do s.fmt = 6'($urandom_range(0, 63));
            while (crop_scoreboard::pixel_size(s.fmt) != 0);
         end
         ZERO_SIZE: begin
            case ($urandom_range(0, 3))
               0:       s.src_w = '0;
               1:       s.src_h = '0;
               2:       s.width = '0;
               default: s.height = '0;
            endcase
         end
         OVER_RIGHT: begin
            floor_v = int'(s.src_w) - int'(s.width) + 1;
            s.left = 16'($urandom_range(floor_v, 65535));
         end
         default: begin
            floor_v = int'(s.src_h) - int'(s.height) + 1;
            s.top = 16'($urandom_range(floor_v, 65535));
         end
      endcase
      return s;
   endfunction

   function automatic word_q_type random_words(int n);
      word_q_type q;
      for (int i = 0; i < n; i++) q.push_back(8'($urandom_range(0, 255)));
      return q;
   endfunction

   task automatic drain_results();
      do @(posedge clock);
      while (sb.pending() != 0);
   endtask

   task automatic wait_idle();
      drain_results();
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   task automatic load_setting(input crop_setting_type s, input bit poke_unused);
      logic [prc_pkg::CSR_INDEX_BITS-1:0] idx;
      logic [prc_pkg::CSR_DATA_BITS-1:0]  val;
      for (int r = prc_pkg::REG_SOURCE_WIDTH; r <= prc_pkg::REG_SWAP_SIXTEEN; r++) begin
         idx = prc_pkg::CSR_INDEX_BITS'(r);
         case (idx)
            prc_pkg::REG_SOURCE_WIDTH:  val = s.src_w;
            prc_pkg::REG_SOURCE_HEIGHT: val = s.src_h;
            prc_pkg::REG_CROP_LEFT:     val = s.left;
            prc_pkg::REG_CROP_TOP:      val = s.top;
            prc_pkg::REG_CROP_WIDTH:    val = s.width;
            prc_pkg::REG_CROP_HEIGHT:   val = s.height;
            prc_pkg::REG_FORMAT_CODE:   val = prc_pkg::CSR_DATA_BITS'(s.fmt);
            default:                    val = prc_pkg::CSR_DATA_BITS'(s.swap);
         endcase
         csr_we <= 1'b1;
         csr_index <= idx;
         csr_wdata <= val;
         @(posedge clock);
      end
      if (poke_unused) begin
         csr_index <= prc_pkg::CSR_INDEX_BITS'($urandom_range(
                         int'(prc_pkg::REG_SWAP_SIXTEEN) + 1, 2 ** prc_pkg::CSR_INDEX_BITS - 1));
         csr_wdata <= prc_pkg::CSR_DATA_BITS'($urandom);
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   task automatic send_words(input word_q_type words);
      int burst;
      int gap;
      burst = 0;
      foreach (words[i]) begin
         if (burst == 0) begin
            burst = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if ($urandom_range(0, 30) == 0) begin
               req_tvalid <= 1'b0;
               drain_results();
            end else if (gap > 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         req_tvalid <= 1'b1;
         req_tdata <= words[i];
         do @(posedge clock);
         while (!req_tready);
         burst--;
      end
      req_tvalid <= 1'b0;
   endtask

   task automatic run_setting(input crop_setting_type s, input word_q_type words,
                              input bit poke);
      wait_idle();
      load_setting(s, poke);
      send_words(words);
   endtask

   initial begin
      crop_setting_type s;
      word_q_type       q;
      int               words_total, settings, rejected, count, frame_words, pb;
      bit               big, faulty;
      words_total = 0;
      settings = 0;
      rejected = 0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset geometry: one 8-bit pixel per frame
      q = '{8'h00, 8'hFF, 8'hA5};
      send_words(q);
      run_setting(make_setting(2, 1, 0, 0, 2, 1, {3'd1, prc_pkg::DEPTH_CODE_16}, 1'b1),
                  '{8'h12, 8'h34, 8'h56, 8'h78}, 1'b1);
      run_setting(make_setting(13, 1, 3, 0, 7, 1, {3'd1, prc_pkg::DEPTH_CODE_1}, 1'b1),
                  '{8'hFF, 8'h5A}, 1'b0);
      run_setting(make_setting(65535, 65535, 0, 0, 65535, 65535,
                               {3'd1, prc_pkg::DEPTH_CODE_1}, 1'b0),
                  random_words(3), 1'b0);
      run_setting(make_setting(4, 2, 0, 0, 4, 2, {3'd0, prc_pkg::DEPTH_CODE_8}, 1'b0),
                  random_words(2), 1'b0);
      run_setting(make_setting(4, 2, 0, 0, 4, 2, '1, 1'b1), random_words(1), 1'b0);
      run_setting(make_setting(0, 2, 0, 0, 1, 1, {3'd1, prc_pkg::DEPTH_CODE_8}, 1'b0),
                  random_words(1), 1'b0);
      run_setting(make_setting(4, 0, 0, 0, 1, 1, {3'd1, prc_pkg::DEPTH_CODE_8}, 1'b0),
                  random_words(1), 1'b0);
      run_setting(make_setting(4, 2, 0, 0, 0, 1, {3'd1, prc_pkg::DEPTH_CODE_8}, 1'b0),
                  random_words(1), 1'b0);
      run_setting(make_setting(4, 2, 0, 0, 1, 0, {3'd1, prc_pkg::DEPTH_CODE_8}, 1'b0),
                  random_words(1), 1'b0);
      run_setting(make_setting(65535, 1, 65535, 0, 1, 1, {3'd1, prc_pkg::DEPTH_CODE_1}, 1'b0),
                  random_words(1), 1'b0);
      run_setting(make_setting(4, 3, 0, 2, 4, 2, {3'd1, prc_pkg::DEPTH_CODE_8}, 1'b0),
                  random_words(1), 1'b0);
      settings = 11;
      rejected = 8;
      words_total = 21;

      while (words_total < TARGET_WORDS) begin
         big = ($urandom_range(0, 29) == 0);
         faulty = ($urandom_range(0, 7) == 0);
         if (faulty) begin
            s = pick_fault(fault_type'($urandom_range(0, 3)));
            count = 1 + $urandom_range(0, 2);
            rejected++;
         end else begin
            s = pick_valid(big);
            if (big) begin
               count = $urandom_range(8, 60);
            end else begin
               pb = crop_scoreboard::pixel_size(s.fmt);
               frame_words = int'(s.src_h) * ((int'(s.src_w) * pb + 7) / 8);
               count = frame_words * $urandom_range(1, 3);
               if ($urandom_range(0, 5) == 0) count = $urandom_range(1, count);
            end
         end
         words_total += count;
         run_setting(s, random_words(count), $urandom_range(0, 3) == 0);
         settings++;
      end

      wait_idle();
      $display("Cropped %0d source words under %0d register settings, %0d of them rejected.",
               words_total, settings, rejected);
      $display("Compared %0d result words over sub-byte, wide and byte-swapped pixel formats.",
               sb.checked);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
